>>> hdl/wlss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wlss_pkg;

	localparam int NUM_PAGES  = 4096;
	localparam int IDX_W      = $clog2(NUM_PAGES);
	localparam int ADDR_W     = 24;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
	localparam int OUT_PAGE_W = 12;
	localparam int OP_W       = 2;
	localparam int ERR_W      = 2;
	localparam int THR_W      = 20;
	localparam int CNT_W      = 32;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [THR_W-1:0] THR_RESET = 20'd5000;

	typedef logic [OP_W-1:0]  op_t;
	typedef logic [ERR_W-1:0] err_t;

	localparam op_t OP_READ      = 2'd0;
	localparam op_t OP_WRITE     = 2'd1;
	localparam op_t OP_SWAP_DONE = 2'd2;

	localparam err_t ERR_OK      = 2'd0;
	localparam err_t ERR_RANGE   = 2'd1;
	localparam err_t ERR_NO_SWAP = 2'd2;

	localparam logic [PADDR_W-3:0] REG_THRESHOLD = 1'b0;

	typedef struct packed {
		logic sweep_clear;
		logic accept;
		logic update;
		logic scan_rd;
		logic decide;
		logic out_load;
		logic out_from_hold;
	} wlss_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic need_scan;
		logic out_free;
	} wlss_sts_t;

endpackage

`default_nettype wire

>>> hdl/wlss_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module wlss_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [wlss_pkg::PADDR_W-1:0] paddr,
	input  wire logic [wlss_pkg::PDATA_W-1:0] pwdata,
	output logic      [wlss_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	output logic      [wlss_pkg::THR_W-1:0]   threshold
);
	import wlss_pkg::*;

	logic             wr_en;
	logic [THR_W-1:0] threshold_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
		end else if (wr_en && (paddr[PADDR_W-1:2] == REG_THRESHOLD)) begin
			threshold_q <= pwdata[THR_W-1:0];
		end
	end

	assign prdata    = (paddr[PADDR_W-1:2] == REG_THRESHOLD) ? PDATA_W'(threshold_q) : '0;
	assign threshold = threshold_q;

endmodule

`default_nettype wire

>>> hdl/wlss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wlss_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	output wlss_pkg::wlss_cmd_t      cmd,
	input  wire wlss_pkg::wlss_sts_t sts
);
	import wlss_pkg::*;

	typedef enum logic [6:0] {
		ST_CLEAR    = 7'b0000001,
		ST_IDLE     = 7'b0000010,
		ST_UPD      = 7'b0000100,
		ST_SCAN     = 7'b0001000,
		ST_SCAN_END = 7'b0010000,
		ST_DECIDE   = 7'b0100000,
		ST_HOLD     = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = item_valid & ~item_stall;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.sweep_clear = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				priority if (sts.need_scan) begin
					state_d = ST_SCAN;
				end else if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (sts.out_free) begin
					cmd.out_load      = 1'b1;
					cmd.out_from_hold = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_upd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_UPD)
		else $error("accepted transfer not followed by update");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a stalled result");

endmodule

`default_nettype wire

>>> hdl/wlss_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module wlss_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire wlss_pkg::wlss_cmd_t            cmd,
	output wlss_pkg::wlss_sts_t                 sts,
	input  wire logic [wlss_pkg::OP_W-1:0]       opcode,
	input  wire logic [wlss_pkg::ADDR_W-1:0]     access_address,
	input  wire logic [wlss_pkg::THR_W-1:0]      threshold,
	input  wire logic                           result_stall,
	output logic                                result_valid,
	output logic                                swap_issued,
	output logic      [wlss_pkg::OUT_PAGE_W-1:0] hot_page,
	output logic      [wlss_pkg::OUT_PAGE_W-1:0] cold_page,
	output logic                                swap_pending,
	output logic      [wlss_pkg::ERR_W-1:0]      error_code
);
	import wlss_pkg::*;

	typedef struct packed {
		logic                  issued;
		logic [OUT_PAGE_W-1:0] hot;
		logic [OUT_PAGE_W-1:0] cold;
		logic                  pend;
		err_t                  err;
	} res_t;

	// counter RAM
	logic [CNT_W-1:0] mem [NUM_PAGES];
	logic [CNT_W-1:0] rdata_q;
	logic             rd_en;
	logic [IDX_W-1:0] raddr;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [CNT_W-1:0] wdata;

	logic [PAGE_W-1:0] in_page;
	op_t               op_q;
	logic [PAGE_W-1:0] page_q;
	logic [IDX_W-1:0]  sweep_q;
	logic              sweep_last;

	logic              in_range;
	logic              do_write;
	logic [CNT_W-1:0]  cnt_inc;
	logic [THR_W-1:0]  wsc_q;
	logic [THR_W-1:0]  wsc_inc;
	logic              swap_q;

	logic              scan_vld_s1;
	logic [IDX_W-1:0]  scan_idx_s1;
	logic [CNT_W-1:0]  hi_val_q;
	logic [CNT_W-1:0]  lo_val_q;
	logic [IDX_W-1:0]  hot_idx_q;
	logic [IDX_W-1:0]  cold_idx_q;
	logic              pair_differs;
	logic              do_issue;

	res_t              res;
	res_t              hold_q;
	res_t              out_q;
	logic              out_valid_q;

	assign in_page = access_address[ADDR_W-1:PAGE_SHIFT];

	assign rd_en = cmd.accept | cmd.scan_rd;
	assign raddr = cmd.accept ? IDX_W'(in_page) : sweep_q;
	assign we    = cmd.sweep_clear | (cmd.update & do_write);
	assign waddr = cmd.sweep_clear ? sweep_q : IDX_W'(page_q);
	assign wdata = cmd.sweep_clear ? '0 : cnt_inc;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= opcode;
			page_q <= in_page;
		end
	end

	assign sweep_last = (sweep_q == IDX_W'(NUM_PAGES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_clear || cmd.scan_rd) begin
			sweep_q <= sweep_last ? '0 : sweep_q + IDX_W'(1);
		end
	end

	assign in_range = (32'(page_q) < 32'(NUM_PAGES));
	assign do_write = (op_q == OP_WRITE) && in_range;
	assign cnt_inc  = (rdata_q == '1) ? rdata_q : rdata_q + CNT_W'(1);
	assign wsc_inc  = (wsc_q == '1) ? wsc_q : wsc_q + THR_W'(1);

	assign pair_differs = (hot_idx_q != cold_idx_q);
	assign do_issue     = pair_differs && !swap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsc_q  <= '0;
			swap_q <= 1'b0;
		end else begin
			priority if (cmd.update && do_write) begin
				wsc_q <= wsc_inc;
			end else if (cmd.decide && (!pair_differs || !swap_q)) begin
				wsc_q <= '0;
			end
			priority if (cmd.update && (op_q == OP_SWAP_DONE)) begin
				swap_q <= 1'b0;
			end else if (cmd.decide && do_issue) begin
				swap_q <= 1'b1;
			end
		end
	end

	// hot/cold scan, one counter per cycle; first index wins ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			scan_idx_s1 <= sweep_q;
		end
		if (scan_vld_s1) begin
			if (scan_idx_s1 == '0) begin
				hi_val_q   <= rdata_q;
				lo_val_q   <= rdata_q;
				hot_idx_q  <= '0;
				cold_idx_q <= '0;
			end else begin
				if (rdata_q > hi_val_q) begin
					hi_val_q  <= rdata_q;
					hot_idx_q <= scan_idx_s1;
				end
				if (rdata_q < lo_val_q) begin
					lo_val_q   <= rdata_q;
					cold_idx_q <= scan_idx_s1;
				end
			end
		end
	end

	always_comb begin
		res      = '0;
		res.err  = ERR_OK;
		res.pend = swap_q;
		priority if (cmd.decide) begin
			if (do_issue) begin
				res.issued = 1'b1;
				res.hot    = OUT_PAGE_W'(hot_idx_q);
				res.cold   = OUT_PAGE_W'(cold_idx_q);
				res.pend   = 1'b1;
			end
		end else begin
			unique case (op_q)
				OP_READ, OP_WRITE: begin
					if (!in_range) begin
						res.err = ERR_RANGE;
					end
				end
				OP_SWAP_DONE: begin
					res.pend = 1'b0;
					if (!swap_q) begin
						res.err = ERR_NO_SWAP;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update || cmd.decide) begin
			hold_q <= res;
		end
		if (cmd.out_load) begin
			out_q <= cmd.out_from_hold ? hold_q : res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.sweep_last = sweep_last;
	assign sts.need_scan  = do_write && (wsc_inc >= threshold);
	assign sts.out_free   = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign swap_issued  = out_q.issued;
	assign hot_page     = out_q.hot;
	assign cold_page    = out_q.cold;
	assign swap_pending = out_q.pend;
	assign error_code   = out_q.err;

	a_swap_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(swap_q) |-> $past(cmd.decide))
		else $error("swap flag set outside a check");

	a_issue_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.issued) |-> (out_q.hot != out_q.cold))
		else $error("swap issued for a single page");

	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && !swap_q) |=> (wsc_q == '0))
		else $error("write count not cleared after check");

endmodule

`default_nettype wire

>>> hdl/wear_level_swap_select.sv
// Wear-level swap selector.
// Item channel (item_valid/item_stall, opcode, access_address) carries read,
// write and swap-complete events; result channel (result_valid/result_stall)
// returns one transfer per item: swap_issued, hot_page, cold_page,
// swap_pending, error_code. swap_threshold sits at APB address 0.
// Item flow: an item is accepted and updated in the next cycle; with no scan
// and a free output its result is registered at the end of that cycle. A new
// item waits for this read-modify-write of one counter in the single counter RAM.
// A write that brings the running count to or past the threshold scans all
// NUM_PAGES counters through the RAM read port, one per cycle, before its
// result is decided.
// Reset: the counter RAM is cleared, one entry per cycle, with item_stall
// high; the threshold register is writable meanwhile.
// Receiver stall: the result register holds its transfer; the next item is
// still accepted and processed, and its result waits in a holding register
// until the output frees, with item_stall high in the meantime.
`timescale 1ns / 1ps
`default_nettype none

module wear_level_swap_select (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [wlss_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [wlss_pkg::PDATA_W-1:0]     pwdata,
	output logic      [wlss_pkg::PDATA_W-1:0]     prdata,
	output logic                                  pready,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic [wlss_pkg::OP_W-1:0]        opcode,
	input  wire logic [wlss_pkg::ADDR_W-1:0]      access_address,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output logic                                  swap_issued,
	output logic      [wlss_pkg::OUT_PAGE_W-1:0]  hot_page,
	output logic      [wlss_pkg::OUT_PAGE_W-1:0]  cold_page,
	output logic                                  swap_pending,
	output logic      [wlss_pkg::ERR_W-1:0]       error_code
);
	import wlss_pkg::*;

	wlss_cmd_t        cmd;
	wlss_sts_t        sts;
	logic [THR_W-1:0] threshold;

	wlss_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	wlss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	wlss_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.access_address (access_address),
		.threshold      (threshold),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.swap_issued    (swap_issued),
		.hot_page       (hot_page),
		.cold_page      (cold_page),
		.swap_pending   (swap_pending),
		.error_code     (error_code)
	);

endmodule

`default_nettype wire

>>> tb/wear_level_swap_select_test.sv
`timescale 1ns / 1ps

module wear_level_swap_select_test;

	import wlss_pkg::*;

	localparam op_t OP_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};

	typedef struct packed {
		logic                  issued;
		logic [OUT_PAGE_W-1:0] hot;
		logic [OUT_PAGE_W-1:0] cold;
		logic                  pending;
		err_t                  err;
	} swap_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [PDATA_W-1:0]    pwdata;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic                  item_valid;
	logic                  item_stall;
	logic [OP_W-1:0]       opcode;
	logic [ADDR_W-1:0]     access_address;
	logic                  result_valid;
	logic                  result_stall;
	logic                  swap_issued;
	logic [OUT_PAGE_W-1:0] hot_page;
	logic [OUT_PAGE_W-1:0] cold_page;
	logic                  swap_pending;
	logic [ERR_W-1:0]      error_code;

	// shadow of the block's state
	logic [CNT_W-1:0] page_wear [NUM_PAGES];
	logic [THR_W-1:0] writes_since_scan;
	logic             swap_busy;
	logic [THR_W-1:0] swap_threshold;

	swap_result_t expected_results[$];
	bit failed = 0;
	int sender_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;

	wear_level_swap_select i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.opcode         (opcode),
		.access_address (access_address),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.swap_issued    (swap_issued),
		.hot_page       (hot_page),
		.cold_page      (cold_page),
		.swap_pending   (swap_pending),
		.error_code     (error_code)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic swap_result_t predict_swap(op_t op, logic [ADDR_W-1:0] addr);
		swap_result_t r;
		int unsigned pg;
		int unsigned hi;
		int unsigned lo;
		r = '0;
		pg = addr >> PAGE_SHIFT;
		if (op == OP_READ || op == OP_WRITE) begin
			if (pg >= NUM_PAGES) begin
				r.err = ERR_RANGE;
			end else if (op == OP_WRITE) begin
				if (page_wear[pg] != '1)
					page_wear[pg] = page_wear[pg] + 1'b1;
				if (writes_since_scan != '1)
					writes_since_scan = writes_since_scan + 1'b1;
				if (writes_since_scan >= swap_threshold) begin
					hi = 0;
					lo = 0;
					for (int i = 1; i < NUM_PAGES; i++) begin
						if (page_wear[i] > page_wear[hi])
							hi = i;
						if (page_wear[i] < page_wear[lo])
							lo = i;
					end
					if (hi == lo) begin
						writes_since_scan = '0;
					end else if (!swap_busy) begin
						swap_busy = 1'b1;
						writes_since_scan = '0;
						r.issued = 1'b1;
						r.hot = hi[OUT_PAGE_W-1:0];
						r.cold = lo[OUT_PAGE_W-1:0];
					end
				end
			end
		end else if (op == OP_SWAP_DONE) begin
			if (swap_busy)
				swap_busy = 1'b0;
			else
				r.err = ERR_NO_SWAP;
		end
		r.pending = swap_busy;
		return r;
	endfunction

	task automatic send_item(op_t op, logic [ADDR_W-1:0] addr);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		opcode <= op;
		access_address <= addr;
		do @(posedge clk); while (item_stall);
		expected_results.push_back(predict_swap(op, addr));
	endtask

	task automatic send_random_item();
		int sel;
		op_t op;
		logic [ADDR_W-1:0] addr;
		sel = $urandom_range(0, 99);
		if (sel < 30)
			op = OP_READ;
		else if (sel < 80)
			op = OP_WRITE;
		else if (sel < 95)
			op = OP_SWAP_DONE;
		else
			op = OP_UNUSED;
		// keep scans rare: finish the swap before the count would trigger another check
		if (op == OP_WRITE && swap_busy && writes_since_scan + 1 >= swap_threshold)
			op = OP_SWAP_DONE;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			addr = {PAGE_W'($urandom_range(0, 7)), PAGE_SHIFT'($urandom)};
		else if (sel < 60)
			addr = $urandom_range(0, 1) ? '1 : '0;
		else
			addr = ADDR_W'($urandom);
		send_item(op, addr);
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= THRESHOLD_ADDR;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		swap_threshold = data[THR_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_threshold_readback();
		logic [PDATA_W-1:0] value;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= THRESHOLD_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (value[THR_W-1:0] !== swap_threshold) begin
			$error("swap_threshold: expected %0d, actual %0d", swap_threshold,
				value[THR_W-1:0]);
			failed = 1;
		end
	endtask

	task automatic set_threshold(logic [PDATA_W-1:0] data);
		drain();
		apb_write(data);
	endtask

	// result checker
	always @(posedge clk) begin
		swap_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no item outstanding");
				failed = 1;
			end else begin
				want = expected_results.pop_front();
				if (swap_issued !== want.issued) begin
					$error("swap_issued: expected %0d, actual %0d", want.issued, swap_issued);
					failed = 1;
				end
				if (hot_page !== want.hot) begin
					$error("hot_page: expected %0d, actual %0d", want.hot, hot_page);
					failed = 1;
				end
				if (cold_page !== want.cold) begin
					$error("cold_page: expected %0d, actual %0d", want.cold, cold_page);
					failed = 1;
				end
				if (swap_pending !== want.pending) begin
					$error("swap_pending: expected %0d, actual %0d", want.pending,
						swap_pending);
					failed = 1;
				end
				if (error_code !== want.err) begin
					$error("error_code: expected %0d, actual %0d", want.err, error_code);
					failed = 1;
				end
			end
		end
	end

	// receiver: long hold-off when requested, otherwise random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_stall <= 1'b1;
			hold_cycles--;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic test_register_access();
		check_threshold_readback();
		apb_write(32'h000F_FFFF);
		check_threshold_readback();
		apb_write(32'h7FF0_0000 | THR_RESET);
		check_threshold_readback();
	endtask

	task automatic test_directed_swaps();
		send_item(OP_READ, '0);
		send_item(OP_READ, '1);
		send_item(OP_WRITE, '1);
		send_item(OP_WRITE, '0);
		set_threshold(32'd2);
		send_item(OP_WRITE, 24'h005ABC);
		send_item(OP_WRITE, 24'h005000);
		send_item(OP_WRITE, 24'h005FFF);
		// still pending: check repeats without a new request
		send_item(OP_WRITE, 24'h005123);
		send_item(OP_SWAP_DONE, 24'h123456);
		send_item(OP_SWAP_DONE, '1);
		send_item(OP_UNUSED, '1);
		send_item(OP_UNUSED, '0);
		send_item(OP_WRITE, 24'hFFF000);
		send_item(OP_READ, 24'h800000);
		send_item(OP_SWAP_DONE, '0);
	endtask

	task automatic test_threshold_extremes();
		// upper data bits are dropped: threshold becomes zero
		set_threshold(32'hFFF0_0000);
		check_threshold_readback();
		send_item(OP_WRITE, 24'h00A000);
		send_item(OP_WRITE, 24'h00A000);
		send_item(OP_SWAP_DONE, '0);
		send_item(OP_WRITE, 24'h7FF000);
		send_item(OP_SWAP_DONE, '1);
		set_threshold(32'd1);
		send_item(OP_WRITE, 24'h00A555);
		send_item(OP_SWAP_DONE, 24'h000FFF);
		set_threshold(32'h000F_FFFF);
		check_threshold_readback();
		send_item(OP_WRITE, 24'h00A000);
		send_item(OP_WRITE, 24'h001000);
		send_item(OP_READ, 24'h00AFFF);
	endtask

	task automatic run_random_traffic(int items, int idle, int stall);
		set_threshold(PDATA_W'($urandom_range(8, 40)));
		sender_idle_pct = idle;
		stall_pct = stall;
		repeat (items) send_random_item();
		drain();
	endtask

	task automatic test_random_no_idle();
		run_random_traffic(400, 0, 0);
	endtask

	task automatic test_random_sender_gaps();
		run_random_traffic(350, 69, 0);
	endtask

	task automatic test_random_receiver_stalls();
		run_random_traffic(350, 0, 69);
	endtask

	task automatic test_random_both_idle();
		run_random_traffic(300, 30, 30);
	endtask

	task automatic test_backpressure_fill();
		set_threshold(PDATA_W'($urandom_range(8, 40)));
		sender_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 300;
		repeat (40) send_random_item();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		opcode = OP_READ;
		access_address = '0;
		result_stall = 1'b0;
		for (int i = 0; i < NUM_PAGES; i++)
			page_wear[i] = '0;
		writes_since_scan = '0;
		swap_busy = 1'b0;
		swap_threshold = THR_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_access();
		test_directed_swaps();
		test_threshold_extremes();
		test_random_no_idle();
		test_random_sender_gaps();
		test_random_receiver_stalls();
		test_random_both_idle();
		test_backpressure_fill();

		repeat (20) @(posedge clk);
		if (!failed)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
